// ----- src/assert_macros.svh -----
// Assertion macros shared by the job queue RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TAJQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TAJQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TAJQ_ASSERT(lbl, clk, rst_n, prop)
`define TAJQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- src/tajq_pkg.sv -----
// Constants, types and helpers for the timed actuator job queue.
// No dependencies; used by tajq_fifo and timed_actuator_job_queue.
package tajq_pkg;

    localparam int QUEUE_DEPTH = 7;
    localparam int ACTUATORS   = 8;
    localparam int DUR_W       = 16;
    localparam int ACT_W       = 3;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic FUNC_RUN  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef logic [ACT_W-1:0]     t_act;
    typedef logic [DUR_W-1:0]     t_dur;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [ACTUATORS-1:0] t_lines;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_cmd;

    typedef struct packed {
        t_count count;
        logic   full;
        logic   empty;
    } t_fifo_stat;

    // one-hot drive; an actuator number with no line raises nothing
    function automatic t_lines drive_decode(input logic busy, input t_act act);
        t_lines v;
        v = '0;
        for (int i = 0; i < ACTUATORS; i++) begin
            v[i] = busy && (act == ACT_W'(i));
        end
        return v;
    endfunction

endpackage

// ----- src/tajq_fifo.sv -----
// Shift FIFO of waiting jobs: write at the fill count, read at the head.
// Depends on tajq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tajq_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tajq_pkg::t_fifo_cmd i_cmd,
    input  tajq_pkg::t_act     i_act,
    input  tajq_pkg::t_dur     i_dur,
    output tajq_pkg::t_act     o_head_act,
    output tajq_pkg::t_dur     o_head_dur,
    output tajq_pkg::t_fifo_stat o_stat
);
    import tajq_pkg::*;

    t_act   r_act [QUEUE_DEPTH];
    t_dur   r_dur [QUEUE_DEPTH];
    t_count r_count;
    t_count n_count;

    always_comb begin
        n_count = r_count;
        if (i_cmd.push && !o_stat.full) begin
            n_count = r_count + COUNT_W'(1);
        end else if (i_cmd.pop && !o_stat.empty) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // entries carry no reset; only slots below the count are ever read
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_cmd.push && r_count == COUNT_W'(i)) begin
                r_act[i] <= i_act;
                r_dur[i] <= i_dur;
            end else if (i_cmd.pop && i < QUEUE_DEPTH - 1) begin
                r_act[i] <= r_act[(i + 1) % QUEUE_DEPTH];
                r_dur[i] <= r_dur[(i + 1) % QUEUE_DEPTH];
            end
        end
    end

    assign o_head_act   = r_act[0];
    assign o_head_dur   = r_dur[0];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == COUNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    `TAJQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= COUNT_W'(QUEUE_DEPTH))
    `TAJQ_ASSERT(a_no_push_pop, i_clk, i_rst_n, !(i_cmd.push && i_cmd.pop))
    `TAJQ_ASSERT(a_pop_dec, i_clk, i_rst_n, (i_cmd.pop && !o_stat.empty) |=> (r_count == $past(r_count) - COUNT_W'(1)))
endmodule

// ----- src/timed_actuator_job_queue.sv -----
// Timed actuator job queue: each beat taken in gives one beat out in the next cycle.
// One beat per cycle while i_out_ready is high; the output register refills as taken.
// Every state update (start, queue, drop, tick count, pop) is one combinational
// pass between the job/queue registers and the output register.
// Reset (synchronous, active low): idle, actuator 0, queue empty, no output pending.
// Depends on tajq_pkg, tajq_fifo and assert_macros.svh.
`include "assert_macros.svh"
module timed_actuator_job_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_func,
    input  tajq_pkg::t_act           i_actuator,
    input  tajq_pkg::t_dur           i_duration,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_running,
    output tajq_pkg::t_act           o_active_actuator,
    output tajq_pkg::t_lines         o_drive_lines,
    output tajq_pkg::t_count         o_queued,
    output logic                     o_dropped
);
    import tajq_pkg::*;

    logic       r_busy,  n_busy;
    t_act       r_cur,   n_cur;
    t_dur       r_left,  n_left;
    logic       n_drop;
    t_count     n_count;
    logic       in_fire;

    t_fifo_cmd  fifo_cmd;
    t_fifo_stat fifo_stat;
    t_act       head_act;
    t_dur       head_dur;

    logic       r_out_valid;
    logic       r_o_running;
    t_act       r_o_act;
    t_lines     r_o_lines;
    t_count     r_o_queued;
    logic       r_o_dropped;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    tajq_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (fifo_cmd),
        .i_act      (i_actuator),
        .i_dur      (i_duration),
        .o_head_act (head_act),
        .o_head_dur (head_dur),
        .o_stat     (fifo_stat)
    );

    always_comb begin
        n_busy   = r_busy;
        n_cur    = r_cur;
        n_left   = r_left;
        n_drop   = 1'b0;
        fifo_cmd = '0;
        if (in_fire) begin
            case (i_func)
                FUNC_RUN: begin
                    if (!r_busy) begin
                        n_busy = 1'b1;
                        n_cur  = i_actuator;
                        n_left = i_duration;
                    end else if (!fifo_stat.full) begin
                        fifo_cmd.push = 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                end
                FUNC_TICK: begin
                    if (!r_busy) begin
                        // start tick is not counted
                        if (!fifo_stat.empty) begin
                            fifo_cmd.pop = 1'b1;
                            n_busy = 1'b1;
                            n_cur  = head_act;
                            n_left = head_dur;
                        end
                    end else if (r_left == '0) begin
                        n_busy = 1'b0;
                    end else begin
                        n_left = r_left - DUR_W'(1);
                    end
                end
                default: ;
            endcase
        end
        n_count = fifo_stat.count + COUNT_W'(fifo_cmd.push) - COUNT_W'(fifo_cmd.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cur       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cur  <= n_cur;
            r_left <= n_left;
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_o_running <= n_busy;
            r_o_act     <= n_cur;
            r_o_lines   <= drive_decode(n_busy, n_cur);
            r_o_queued  <= n_count;
            r_o_dropped <= n_drop;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_running         = r_o_running;
    assign o_active_actuator = r_o_act;
    assign o_drive_lines     = r_o_lines;
    assign o_queued          = r_o_queued;
    assign o_dropped         = r_o_dropped;

    `TAJQ_ASSERT(a_lines_idle, i_clk, i_rst_n, (r_out_valid && !r_o_running) |-> (r_o_lines == '0))
    `TAJQ_ASSERT(a_drop_full, i_clk, i_rst_n, n_drop |-> (r_busy && fifo_stat.full))
    `TAJQ_ASSERT(a_stall_hold, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_o_queued)))
    `TAJQ_ASSERT_ALWAYS(a_ready_empty, i_clk, !r_out_valid |-> o_in_ready)
endmodule
